>>> rtl/cjrp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cjrp_pkg;

    // grammar limits
    localparam int MAX_KEYS  = 2;
    localparam int MAX_PAIRS = 4;

    localparam logic [4:0] ADDR_LEN  = 5'd2;
    localparam logic [4:0] LEASE_LEN = 5'd5;

    // cbor major types
    localparam logic [2:0] MAJOR_ARRAY = 3'd4;
    localparam logic [2:0] MAJOR_MAP   = 3'd5;

    // cose key labels
    localparam logic [7:0] LBL_KTY     = 8'h01;
    localparam logic [7:0] LBL_KID     = 8'h02;
    localparam logic [7:0] LBL_ALG     = 8'h03;
    localparam logic [7:0] LBL_KEY_OPS = 8'h04;
    localparam logic [7:0] LBL_BASE_IV = 8'h05;
    localparam logic [7:0] LBL_K       = 8'h20;

    // byte roles
    localparam logic [2:0] ROLE_STRUCT = 3'd0;
    localparam logic [2:0] ROLE_KTY    = 3'd1;
    localparam logic [2:0] ROLE_KID    = 3'd2;
    localparam logic [2:0] ROLE_KEY    = 3'd3;
    localparam logic [2:0] ROLE_ADDR   = 3'd4;
    localparam logic [2:0] ROLE_LEASE  = 3'd5;
    localparam logic [2:0] ROLE_SKIP   = 3'd6;
    localparam logic [2:0] ROLE_ERR    = 3'd7;

    typedef enum logic [15:0] {
        PH_TOP       = 16'h0001,
        PH_KEYSET    = 16'h0002,
        PH_MAP       = 16'h0004,
        PH_LABEL     = 16'h0008,
        PH_KTY       = 16'h0010,
        PH_KIDLEN    = 16'h0020,
        PH_KLEN      = 16'h0040,
        PH_SKIPLEN   = 16'h0080,
        PH_KIDDATA   = 16'h0100,
        PH_KDATA     = 16'h0200,
        PH_SKIPDATA  = 16'h0400,
        PH_ADDRHDR   = 16'h0800,
        PH_ADDRLEN   = 16'h1000,
        PH_ADDRDATA  = 16'h2000,
        PH_LEASELEN  = 16'h4000,
        PH_LEASEDATA = 16'h8000
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic [1:0] top_items;
        logic [4:0] keys_left;
        logic [4:0] pairs_left;
        logic [4:0] field_left;
        logic [4:0] key_number;
        logic [4:0] field_offset;
        logic [1:0] addr_items;
        logic       failed;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        phase:        PH_TOP,
        top_items:    2'd0,
        keys_left:    5'd0,
        pairs_left:   5'd0,
        field_left:   5'd0,
        key_number:   5'd0,
        field_offset: 5'd0,
        addr_items:   2'd0,
        failed:       1'b0
    };

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_beat_t;

    typedef struct packed {
        logic [2:0] out_role;
        logic [4:0] out_key_index;
        logic [4:0] out_offset;
        logic       out_done;
        logic       out_status;
    } out_beat_t;

endpackage

`default_nettype wire

>>> rtl/cjrp_step.sv
`timescale 1ns / 1ps
`default_nettype none

module cjrp_step #(
    parameter int MAX_KEYS  = cjrp_pkg::MAX_KEYS,
    parameter int MAX_PAIRS = cjrp_pkg::MAX_PAIRS
) (
    input  cjrp_pkg::parse_state_t cur,
    input  cjrp_pkg::in_beat_t     beat,
    output cjrp_pkg::parse_state_t nxt,
    output cjrp_pkg::out_beat_t    result
);
    import cjrp_pkg::*;

    function automatic parse_state_t finish_pair(parse_state_t s);
        parse_state_t r;
        r = s;
        r.pairs_left = s.pairs_left - 5'd1;
        if (r.pairs_left != 5'd0) begin
            r.phase = PH_LABEL;
        end
        else begin
            r.keys_left  = s.keys_left - 5'd1;
            r.key_number = s.key_number + 5'd1;
            if (r.keys_left != 5'd0) begin
                r.phase = PH_MAP;
            end
            else if (s.top_items == 2'd2) begin
                r.phase = PH_ADDRHDR;
            end
            else begin
                r.phase = PH_TOP;
            end
        end
        return r;
    endfunction

    function automatic parse_state_t start_field(parse_state_t s, logic [4:0] len,
                                                 phase_t data_phase);
        parse_state_t r;
        r = s;
        r.field_left   = len;
        r.field_offset = 5'd0;
        if (len == 5'd0) begin
            r = finish_pair(r);
        end
        else begin
            r.phase = data_phase;
        end
        return r;
    endfunction

    logic [2:0]   major;
    logic [4:0]   ai;
    logic         bad;
    logic [2:0]   role;
    logic [4:0]   kidx;
    logic [4:0]   off;
    logic         complete_cur;
    logic         complete_nxt;
    parse_state_t work;

    assign major        = beat.in_byte[7:5];
    assign ai           = beat.in_byte[4:0];
    assign complete_cur = (cur.phase == PH_TOP) && (cur.top_items != 2'd0);

    always_comb
    begin
        work = cur;
        bad  = 1'b0;
        role = ROLE_STRUCT;
        kidx = 5'd0;
        off  = 5'd0;
        if (cur.failed || complete_cur) begin
            bad = 1'b1;
        end
        else begin
            case (cur.phase)
                PH_TOP:
                begin
                    if (major != MAJOR_ARRAY || ai == 5'd0 || ai > 5'd2) begin
                        bad = 1'b1;
                    end
                    else begin
                        work.top_items = ai[1:0];
                        work.phase     = PH_KEYSET;
                    end
                end
                PH_KEYSET:
                begin
                    if (major != MAJOR_ARRAY || ai == 5'd0 || ai > 5'(MAX_KEYS)) begin
                        bad = 1'b1;
                    end
                    else begin
                        work.keys_left  = ai;
                        work.key_number = 5'd0;
                        work.phase      = PH_MAP;
                    end
                end
                PH_MAP:
                begin
                    kidx = cur.key_number;
                    if (major != MAJOR_MAP || ai == 5'd0 || ai > 5'(MAX_PAIRS)) begin
                        bad = 1'b1;
                    end
                    else begin
                        work.pairs_left = ai;
                        work.phase      = PH_LABEL;
                    end
                end
                PH_LABEL:
                begin
                    kidx = cur.key_number;
                    case (beat.in_byte)
                        LBL_KTY: work.phase = PH_KTY;
                        LBL_KID: work.phase = PH_KIDLEN;
                        LBL_ALG:
                        begin
                            // alg carries one value byte with no length byte
                            work.field_left   = 5'd1;
                            work.field_offset = 5'd0;
                            work.phase        = PH_SKIPDATA;
                        end
                        LBL_KEY_OPS: work.phase = PH_SKIPLEN;
                        LBL_BASE_IV: work.phase = PH_SKIPLEN;
                        LBL_K:       work.phase = PH_KLEN;
                        default:     bad = 1'b1;
                    endcase
                end
                PH_KTY:
                begin
                    role = ROLE_KTY;
                    kidx = cur.key_number;
                    work = finish_pair(cur);
                end
                PH_KIDLEN:
                begin
                    kidx = cur.key_number;
                    work = start_field(cur, ai, PH_KIDDATA);
                end
                PH_KLEN:
                begin
                    kidx = cur.key_number;
                    work = start_field(cur, ai, PH_KDATA);
                end
                PH_SKIPLEN:
                begin
                    kidx = cur.key_number;
                    work = start_field(cur, ai, PH_SKIPDATA);
                end
                PH_KIDDATA, PH_KDATA, PH_SKIPDATA:
                begin
                    role = (cur.phase == PH_KIDDATA) ? ROLE_KID :
                           (cur.phase == PH_KDATA)   ? ROLE_KEY : ROLE_SKIP;
                    kidx = cur.key_number;
                    off  = cur.field_offset;
                    work.field_offset = cur.field_offset + 5'd1;
                    work.field_left   = cur.field_left - 5'd1;
                    if (work.field_left == 5'd0) begin
                        work = finish_pair(work);
                    end
                end
                PH_ADDRHDR:
                begin
                    if (major != MAJOR_ARRAY || ai == 5'd0 || ai > 5'd2) begin
                        bad = 1'b1;
                    end
                    else begin
                        work.addr_items = ai[1:0];
                        work.phase      = PH_ADDRLEN;
                    end
                end
                PH_ADDRLEN:
                begin
                    if (ai != ADDR_LEN) begin
                        bad = 1'b1;
                    end
                    else begin
                        work.field_left   = ADDR_LEN;
                        work.field_offset = 5'd0;
                        work.phase        = PH_ADDRDATA;
                    end
                end
                PH_ADDRDATA:
                begin
                    role = ROLE_ADDR;
                    off  = cur.field_offset;
                    work.field_offset = cur.field_offset + 5'd1;
                    work.field_left   = cur.field_left - 5'd1;
                    if (work.field_left == 5'd0) begin
                        work.phase = (cur.addr_items == 2'd2) ? PH_LEASELEN : PH_TOP;
                    end
                end
                PH_LEASELEN:
                begin
                    if (ai != LEASE_LEN) begin
                        bad = 1'b1;
                    end
                    else begin
                        work.field_left   = LEASE_LEN;
                        work.field_offset = 5'd0;
                        work.phase        = PH_LEASEDATA;
                    end
                end
                PH_LEASEDATA:
                begin
                    role = ROLE_LEASE;
                    off  = cur.field_offset;
                    work.field_offset = cur.field_offset + 5'd1;
                    work.field_left   = cur.field_left - 5'd1;
                    if (work.field_left == 5'd0) begin
                        work.phase = PH_TOP;
                    end
                end
                default:
                begin
                    bad = 1'b1;
                end
            endcase
        end

        if (bad) begin
            work.failed = 1'b1;
            role        = ROLE_ERR;
            kidx        = 5'd0;
            off         = 5'd0;
        end
    end

    assign complete_nxt = (work.phase == PH_TOP) && (work.top_items != 2'd0);

    // message end puts the parser back to its reset state
    assign nxt = beat.in_last ? STATE_RESET : work;

    assign result.out_role      = role;
    assign result.out_key_index = kidx;
    assign result.out_offset    = off;
    assign result.out_done      = beat.in_last;
    assign result.out_status    = beat.in_last & (work.failed | ~complete_nxt);

endmodule

`default_nettype wire

>>> rtl/cbor_join_response_parser_core.sv
// channel | handshake               | payload                      | beat
// --------+-------------------------+------------------------------+---------------------
// in      | in_valid / in_ready     | in_beat  (in_byte, in_last)  | one message byte
// out     | out_valid / out_ready   | out_beat (role, key index,   | one tag per in byte
//         |                         |   offset, done, status)      |
//
// one result beat per input beat, one beat per cycle sustained while out_ready stays high
// a byte passes through the input register, then the parse step into the result register
// the parse state advances by one combinational step per byte, which sets the rate
// rst_n clears both valid flags and the parse state; payload registers are not reset
// a stalled output holds its beat and backs up into the input register

`timescale 1ns / 1ps
`default_nettype none

module cbor_join_response_parser_core #(
    parameter int MAX_KEYS  = cjrp_pkg::MAX_KEYS,
    parameter int MAX_PAIRS = cjrp_pkg::MAX_PAIRS
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  cjrp_pkg::in_beat_t  in_beat,
    output logic                out_valid,
    input  wire                 out_ready,
    output cjrp_pkg::out_beat_t out_beat
);
    import cjrp_pkg::*;

    logic         in_valid_reg;
    logic         in_valid_next;
    in_beat_t     in_beat_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    out_beat_t    out_beat_reg;
    out_beat_t    step_result;
    logic         advance;

    cjrp_step #(
        .MAX_KEYS  (MAX_KEYS),
        .MAX_PAIRS (MAX_PAIRS)
    ) u_step (
        .cur    (state_reg),
        .beat   (in_beat_reg),
        .nxt    (state_next),
        .result (step_result)
    );

    // a beat moves into the result register when that register is free or draining
    assign advance        = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready       = !in_valid_reg || advance;
    assign in_valid_next  = (in_valid && in_ready) || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            in_beat_reg <= in_beat;
        end
        if (advance) begin
            out_beat_reg <= step_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

    // the last byte of a message leaves a clean parser behind
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_beat_reg.in_last |=> state_reg.phase == PH_TOP && !state_reg.failed)
        else $error("parser state not cleared after last byte");

    // once failed, every further byte is tagged as an error
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && state_reg.failed |=> out_beat_reg.out_role == ROLE_ERR)
        else $error("byte after failure not tagged as error");

    // an error-tagged last byte can never report success
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_beat_reg.out_done && out_beat_reg.out_role == ROLE_ERR
        |-> out_beat_reg.out_status)
        else $error("error byte reported success");

    // status is only meaningful on the done beat
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_beat_reg.out_done |-> !out_beat_reg.out_status)
        else $error("status set without done");

endmodule

`default_nettype wire
